// File: hw/rtl/quantized_conv_mac_requant_defines.svh
// Assertion macros shared by the quantized MAC/requant block.
// Needs clk_i and rst_ni in the scope of the including module.
`ifndef QUANTIZED_CONV_MAC_REQUANT_DEFINES_SVH
`define QUANTIZED_CONV_MAC_REQUANT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define QCMR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define QCMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/qcmr_pkg.sv
// Shared constants and types of the quantized MAC/requant block.
// No dependencies.
package qcmr_pkg;

  localparam int unsigned ACC_WIDTH_DEF  = 32;
  localparam int unsigned MULT_WIDTH_DEF = 32;

  localparam int unsigned DATA_W      = 8;
  localparam int unsigned BIAS_W      = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned SHIFT_W     = 6;
  localparam int unsigned QUEUE_DEPTH = 2;

  // saturation point of the requantized value before the zero point
  localparam logic [DATA_W-1:0] Q_SAT = 8'd255;

  localparam logic [DATA_W-1:0] OUT_MIN_RST = 8'h80;  // -128
  localparam logic [DATA_W-1:0] OUT_MAX_RST = 8'h7F;  // 127

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MULT  = 3'd0,
    REG_SHIFT = 3'd1,
    REG_ZP    = 3'd2,
    REG_MIN   = 3'd3,
    REG_MAX   = 3'd4
  } reg_idx_e;

  // requant settings seen by the back end
  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic [DATA_W-1:0]  zp;
    logic [DATA_W-1:0]  omin;
    logic [DATA_W-1:0]  omax;
  } cfg_t;

endpackage

// File: hw/rtl/qcmr_in_if.sv
// Input channel: one weight/activation tap per item.
// Depends on qcmr_pkg.
interface qcmr_in_if;
  import qcmr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] weight;
  logic signed [DATA_W-1:0] activation;
  logic signed [BIAS_W-1:0] bias;
  logic                     last;

  modport source (output valid, weight, activation, bias, last, input ready);
  modport sink   (input valid, weight, activation, bias, last, output ready);
endinterface

// File: hw/rtl/qcmr_out_if.sv
// Result channel: one requantized activation per item.
// Depends on qcmr_pkg.
interface qcmr_out_if;
  import qcmr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

// File: hw/rtl/qcmr_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on qcmr_pkg.
interface qcmr_cfg_if;
  import qcmr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/qcmr_front.sv
// Front end: takes taps, runs the wrapping accumulator, closes a sum on last.
// Depends on qcmr_pkg and qcmr_in_if.
module qcmr_front #(
  parameter int unsigned ACC_WIDTH = qcmr_pkg::ACC_WIDTH_DEF,
  parameter int unsigned SUM_W     = ACC_WIDTH - 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  qcmr_in_if.sink          in_i,
  input  logic             q_full_i,
  output logic             push_o,
  output logic [SUM_W-1:0] push_data_o
);
  import qcmr_pkg::*;

  logic                     accept;
  logic signed [2*DATA_W-1:0] prod;
  logic [ACC_WIDTH-1:0]     acc_q, acc_d;
  logic [ACC_WIDTH-1:0]     mac_sum;
  logic [ACC_WIDTH-1:0]     total;
  logic                     positive;

  // one tap per cycle while the queue has room
  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;

  // multiply-accumulate, then the bias for a closing tap
  assign prod    = in_i.weight * in_i.activation;
  assign mac_sum = acc_q + ACC_WIDTH'(prod);
  assign total   = mac_sum + ACC_WIDTH'(in_i.bias);

  // ReLU: non-positive sums requantize to zero, sent as a zero magnitude
  assign positive    = (total != '0) && !total[ACC_WIDTH-1];
  assign push_o      = accept && in_i.last;
  assign push_data_o = positive ? total[SUM_W-1:0] : '0;

  always_comb begin
    acc_d = acc_q;
    if (accept) begin
      acc_d = in_i.last ? '0 : mac_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

// File: hw/rtl/qcmr_queue.sv
// Small register FIFO between the accumulator and the requant sequencer.
// No dependencies.
module qcmr_queue #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             full_o,
  output logic             empty_o
);
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: hw/rtl/qcmr_back.sv
// Back end: requantizes one closed sum (split multiply, round, shift, zero point, clamp).
// Depends on qcmr_pkg and qcmr_out_if.
module qcmr_back #(
  parameter int unsigned MULT_WIDTH = qcmr_pkg::MULT_WIDTH_DEF,
  parameter int unsigned SUM_W      = qcmr_pkg::ACC_WIDTH_DEF - 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  logic [SUM_W-1:0]      q_data_i,
  output logic                  pop_o,
  input  logic [MULT_WIDTH-1:0] mult_i,
  input  qcmr_pkg::cfg_t        cfg_i,
  qcmr_out_if.source            res_o
);
  import qcmr_pkg::*;

  localparam int unsigned LO_W   = (SUM_W + 1) / 2;
  localparam int unsigned HI_W   = SUM_W - LO_W;
  localparam int unsigned FULL_W = SUM_W + MULT_WIDTH;
  // room for the full product and a rounding term up to bit 62
  localparam int unsigned PW     = ((FULL_W > 63) ? FULL_W : 63) + 1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MLO  = 6'b000010,
    ST_MHI  = 6'b000100,
    ST_ADD  = 6'b001000,
    ST_SHF  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  state_e                     state_q, state_d;
  logic [SUM_W-1:0]           sum_q;
  logic [PW-1:0]              prod_q;
  logic [HI_W+MULT_WIDTH-1:0] part_q;
  logic [DATA_W-1:0]          qv_q;
  logic                       res_valid_q;
  logic [DATA_W-1:0]          res_q;

  logic [LO_W+MULT_WIDTH-1:0] lo_prod;
  logic [HI_W+MULT_WIDTH-1:0] hi_prod;
  logic [PW-1:0]              rnd;
  logic [PW-1:0]              shifted;
  logic                       out_free;
  logic                       load_res;
  logic signed [DATA_W+1:0]   v_sum;
  logic signed [DATA_W+1:0]   v_lo;
  logic signed [DATA_W+1:0]   v_hi;
  logic signed [DATA_W+1:0]   v_clamp;

  // partial products, one per cycle
  assign lo_prod = sum_q[LO_W-1:0] * mult_i;
  assign hi_prod = sum_q[SUM_W-1:LO_W] * mult_i;

  // round half up at the shift point
  assign rnd     = (PW'(1) << cfg_i.shift) >> 1;
  assign shifted = prod_q >> cfg_i.shift;

  // zero point and clamp, upper bound first
  assign v_sum = $signed({2'b00, qv_q}) + $signed({{2{cfg_i.zp[DATA_W-1]}}, cfg_i.zp});
  assign v_lo  = $signed({{2{cfg_i.omin[DATA_W-1]}}, cfg_i.omin});
  assign v_hi  = $signed({{2{cfg_i.omax[DATA_W-1]}}, cfg_i.omax});
  always_comb begin
    v_clamp = v_sum;
    if (v_clamp > v_hi) begin
      v_clamp = v_hi;
    end
    if (v_clamp < v_lo) begin
      v_clamp = v_lo;
    end
  end

  assign out_free = !res_valid_q || res_o.ready;
  assign load_res = (state_q == ST_OUT) && out_free;
  assign pop_o    = (state_q == ST_IDLE) && !q_empty_i;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (!q_empty_i) state_d = ST_MLO;
      ST_MLO:  state_d = ST_MHI;
      ST_MHI:  state_d = ST_ADD;
      ST_ADD:  state_d = ST_SHF;
      ST_SHF:  state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_res) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sum_q <= q_data_i;
    end
    if (state_q == ST_MLO) begin
      prod_q <= PW'(lo_prod);
    end
    if (state_q == ST_MHI) begin
      part_q <= hi_prod;
    end
    if (state_q == ST_ADD) begin
      prod_q <= prod_q + (PW'(part_q) << LO_W) + rnd;
    end
    if (state_q == ST_SHF) begin
      qv_q <= (|shifted[PW-1:DATA_W]) ? Q_SAT : shifted[DATA_W-1:0];
    end
    if (load_res) begin
      res_q <= v_clamp[DATA_W-1:0];
    end
  end

  assign res_o.valid  = res_valid_q;
  assign res_o.result = res_q;

endmodule

// File: hw/rtl/quantized_conv_mac_requant.sv
// Top level of the int8 convolution MAC with requantization.
// Depends on qcmr_pkg, the channel interfaces, qcmr_front, qcmr_queue, qcmr_back and the defines header.
//
//   channel | dir | carries                              | item taken when
//   in_i    | in  | weight, activation, bias, last       | valid && ready
//   res_o   | out | result                               | valid && ready
//   cfg_i   | in  | index, data (register write)         | valid && ready
//
// Taps: one item per cycle, stalled only while the two-entry sum queue is full.
// Each closing tap passes through the requant sequencer (two partial products,
// round add, shift, clamp), which takes one sum at a time and sets the
// sustained rate for outputs. Reset is asynchronous, active low; it clears the
// accumulator, queue, sequencer and registers to their defaults. Results wait
// in an output register; a stalled sink stops the sequencer, then taps once the queue fills.
`include "quantized_conv_mac_requant_defines.svh"

module quantized_conv_mac_requant #(
  parameter int unsigned ACC_WIDTH  = qcmr_pkg::ACC_WIDTH_DEF,
  parameter int unsigned MULT_WIDTH = qcmr_pkg::MULT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  qcmr_in_if.sink     in_i,
  qcmr_out_if.source  res_o,
  qcmr_cfg_if.sink    cfg_i
);
  import qcmr_pkg::*;

  localparam int unsigned SUM_W = ACC_WIDTH - 1;

  logic [MULT_WIDTH-1:0] mult_q;
  cfg_t                  cfg_q;
  logic                  cfg_we;

  logic                  q_push;
  logic [SUM_W-1:0]      q_push_data;
  logic                  q_pop;
  logic [SUM_W-1:0]      q_pop_data;
  logic                  q_full;
  logic                  q_empty;

  // register writes, always taken
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q     <= '0;
      cfg_q.shift <= '0;
      cfg_q.zp    <= '0;
      cfg_q.omin  <= OUT_MIN_RST;
      cfg_q.omax  <= OUT_MAX_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_e'(cfg_i.index))
        REG_MULT:  mult_q      <= cfg_i.data[MULT_WIDTH-1:0];
        REG_SHIFT: cfg_q.shift <= cfg_i.data[SHIFT_W-1:0];
        REG_ZP:    cfg_q.zp    <= cfg_i.data[DATA_W-1:0];
        REG_MIN:   cfg_q.omin  <= cfg_i.data[DATA_W-1:0];
        REG_MAX:   cfg_q.omax  <= cfg_i.data[DATA_W-1:0];
        default:   ;
      endcase
    end
  end

  qcmr_front #(
    .ACC_WIDTH (ACC_WIDTH),
    .SUM_W     (SUM_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .push_data_o (q_push_data)
  );

  qcmr_queue #(
    .WIDTH (SUM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  qcmr_back #(
    .MULT_WIDTH (MULT_WIDTH),
    .SUM_W      (SUM_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_pop_data),
    .pop_o     (q_pop),
    .mult_i    (mult_q),
    .cfg_i     (cfg_q),
    .res_o     (res_o)
  );

  // checks
  `QCMR_ASSERT_IMPL(a_no_overflow, q_push, !q_full, "sum pushed into a full queue")
  `QCMR_ASSERT_IMPL(a_no_underflow, q_pop, !q_empty, "pop from an empty queue")
  `QCMR_ASSERT_IMPL(a_last_queued, in_i.valid && in_i.ready && in_i.last, q_push,
                    "closing tap did not reach the queue")
  `QCMR_ASSERT_NEXT(a_pop_then_busy, q_pop, !q_pop, "back end popped twice in a row")

endmodule

// File: tb/quantized_conv_mac_requant_tb.sv
// Self-checking testbench for quantized_conv_mac_requant: int8 taps are streamed in and
// every requantized result is checked against a scoreboard that tracks the accumulator.
// Depends on qcmr_pkg, the qcmr channel interfaces and the block itself.
module quantized_conv_mac_requant_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qcmr_pkg::*;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned ACC_W          = ACC_WIDTH_DEF;
  localparam int unsigned NUM_REGS       = 5;
  // sequencer, two-entry queue, output register, plus margin
  localparam int unsigned DRAIN_CYCLES   = 24;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned MAX_BURST      = 40;
  localparam int unsigned MAX_GAP        = 10;
  localparam int unsigned HOLDOFF_CYCLES = 400;
  localparam int unsigned HOLDOFF_AT     = 10;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS    = 97;
  localparam int unsigned HOLDOFF_PHASE  = 3;
  localparam int unsigned CROSSED_PHASE  = 6;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  typedef logic [ACC_W-1:0] acc_t;
  typedef enum int unsigned {RX_FREE, RX_MOSTLY, RX_HALF, RX_SPARSE} rx_mode_e;

  // Tracks the accumulator and register file, predicts each requantized output
  // and compares the block's results against it in order.
  class requant_scoreboard;
    acc_t                     acc;
    logic [CFG_DATA_W-1:0]    mult;
    logic [SHIFT_W-1:0]       shift;
    logic signed [DATA_W-1:0] zero_point;
    logic signed [DATA_W-1:0] out_min;
    logic signed [DATA_W-1:0] out_max;
    logic [DATA_W-1:0]        expected_results[$];
    int unsigned              taps;
    int unsigned              results;
    int unsigned              errors;

    function new();
      acc        = '0;
      mult       = '0;
      shift      = '0;
      zero_point = '0;
      out_min    = OUT_MIN_RST;
      out_max    = OUT_MAX_RST;
      taps       = 0;
      results    = 0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MULT:  mult       = data;
        REG_SHIFT: shift      = data[SHIFT_W-1:0];
        REG_ZP:    zero_point = data[DATA_W-1:0];
        REG_MIN:   out_min    = data[DATA_W-1:0];
        REG_MAX:   out_max    = data[DATA_W-1:0];
        default: ;  // unmapped index, no effect
      endcase
    endfunction

    function void note_tap(logic signed [DATA_W-1:0] w, logic signed [DATA_W-1:0] a,
                           logic signed [BIAS_W-1:0] bias, logic last);
      logic signed [2*DATA_W-1:0] prod;
      acc_t                       sum;
      logic [79:0]                scaled;
      int                         v;
      taps++;
      prod = w * a;
      sum  = acc + acc_t'(prod);
      if (!last) begin
        acc = sum;
        return;
      end
      sum = sum + acc_t'(bias);
      acc = '0;
      // ReLU: zero or negative sums requantize to 0
      if (sum == '0 || sum[ACC_W-1]) begin
        scaled = '0;
      end else begin
        scaled = 80'(sum) * 80'(mult);
        if (shift != 0) scaled = scaled + (80'd1 << (shift - 1));
        scaled = scaled >> shift;
        if (scaled > 80'd255) scaled = 80'd255;
      end
      // zero point, then upper clamp before lower clamp
      v = int'(scaled[7:0]) + int'(zero_point);
      if (v > out_max) v = out_max;
      if (v < out_min) v = out_min;
      expected_results.push_back(v[DATA_W-1:0]);
    endfunction

    function void check_result(logic [DATA_W-1:0] got);
      logic [DATA_W-1:0] want;
      results++;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%t: result %0d arrived with nothing expected", $time, $signed(got));
        return;
      end
      want = expected_results.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%t: result #%0d mismatch: expected %0d, got %0d",
                   $time, results, $signed(want), $signed(got));
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  qcmr_in_if  in_if();
  qcmr_out_if res_if();
  qcmr_cfg_if cfg_if();

  requant_scoreboard sb;
  int unsigned       burst_left = 0;
  int unsigned       reg_sets   = 0;
  bit                holdoff_req = 1'b0;

  quantized_conv_mac_requant uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // Observe every handshake on the three channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        sb.note_tap(in_if.weight, in_if.activation, in_if.bias, in_if.last);
      if (res_if.valid && res_if.ready) sb.check_result(res_if.result);
      if (cfg_if.valid && cfg_if.ready) sb.set_reg(cfg_if.index, cfg_if.data);
    end
  end

  // Ends the run if no channel moves an item for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("[quantized_conv_mac_requant] ERROR");
    $finish;
  end

  // Result sink: stall pattern of its own, plus one long hold-off on request
  initial begin : result_sink
    rx_mode_e    mode;
    int unsigned span;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      mode = rx_mode_e'($urandom_range(RX_SPARSE, RX_FREE));
      span = $urandom_range(80, 4);
      repeat (span) begin
        @(posedge clk_i);
        if (holdoff_req) begin
          holdoff_req = 1'b0;
          res_if.ready <= 1'b0;
          repeat (HOLDOFF_CYCLES) @(posedge clk_i);
        end
        case (mode)
          RX_FREE:   res_if.ready <= 1'b1;
          RX_MOSTLY: res_if.ready <= ($urandom_range(3, 0) != 0);
          RX_HALF:   res_if.ready <= ($urandom_range(1, 0) != 0);
          default:   res_if.ready <= ($urandom_range(4, 0) == 0);
        endcase
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand_byte();
    case ($urandom_range(9, 0))
      0:       return 8'h80;
      1:       return 8'h7F;
      2:       return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [BIAS_W-1:0] rand_bias();
    case ($urandom_range(19, 0))
      0:             return 32'h7FFF_FFFF;
      1:             return 32'h8000_0000;
      2:             return 32'hFFFF_FFFF;
      3, 4, 5, 6:    return $urandom;
      default:       return $urandom_range(131071, 0) - 65536;
    endcase
  endfunction

  // Taps per output value: mostly short, a few long
  function automatic int unsigned group_len();
    case ($urandom_range(19, 0))
      0:       return $urandom_range(120, 41);
      1, 2:    return $urandom_range(40, 11);
      default: return $urandom_range(10, 1);
    endcase
  endfunction

  // Offer one tap, in bursts separated by random gaps
  task automatic send_tap(logic signed [DATA_W-1:0] w, logic signed [DATA_W-1:0] a,
                          logic signed [BIAS_W-1:0] bias, logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(MAX_GAP, 1);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(MAX_BURST, 1);
    end
    in_if.valid      <= 1'b1;
    in_if.weight     <= w;
    in_if.activation <= a;
    in_if.bias       <= bias;
    in_if.last       <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic cfg_write_item(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  // Write all registers back to back, then one unmapped index; unused upper data bits are random
  task automatic program_regs(logic [CFG_DATA_W-1:0] m, logic [SHIFT_W-1:0] sh,
                              logic [DATA_W-1:0] zp, logic [DATA_W-1:0] mn,
                              logic [DATA_W-1:0] mx);
    cfg_write_item(REG_MULT,  m);
    cfg_write_item(REG_SHIFT, {26'($urandom), sh});
    cfg_write_item(REG_ZP,    {24'($urandom), zp});
    cfg_write_item(REG_MIN,   {24'($urandom), mn});
    cfg_write_item(REG_MAX,   {24'($urandom), mx});
    cfg_write_item(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, NUM_REGS)), $urandom);
    cfg_if.valid <= 1'b0;
    reg_sets++;
  endtask

  // Stop offering, wait for every expected result, then let the pipeline settle
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_taps(int unsigned n_items, bit with_holdoff);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      len = group_len();
      for (int unsigned k = 0; k < len; k++) begin
        send_tap(rand_byte(), rand_byte(), rand_bias(), k == len - 1);
        if (with_holdoff && sent + k == HOLDOFF_AT) holdoff_req = 1'b1;
      end
      sent += len;
    end
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0]    m;
    logic [SHIFT_W-1:0]       sh;
    logic signed [DATA_W-1:0] zp;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] t;
    logic [63:0]              mask;
    int                       b;
    sb = new();
    rst_ni = 1'b0;
    in_if.valid      <= 1'b0;
    in_if.weight     <= '0;
    in_if.activation <= '0;
    in_if.bias       <= '0;
    in_if.last       <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= '0;
    cfg_if.data      <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Scale of one half: rounding half up, zero and negative sums, overflow, saturation
    program_regs(32'h4000_0000, 6'd31, 8'hFD, 8'h80, 8'h7F);
    send_tap(8'h80, 8'h80, $urandom, 1'b0);
    send_tap(8'h7F, 8'h7F, $urandom, 1'b0);
    send_tap(8'h80, 8'h7F, $urandom, 1'b0);
    send_tap(8'h7F, 8'h80, $urandom, 1'b0);
    send_tap(8'h00, 8'h00, 32'h0000_0000, 1'b1);  // sum 1: half rounds up
    send_tap(8'h01, 8'h03, 32'h0000_0000, 1'b1);  // 1.5 rounds to 2
    send_tap(8'h00, 8'h00, 32'h0000_0000, 1'b1);  // zero sum
    send_tap(8'hFF, 8'h01, 32'h0000_0000, 1'b1);  // negative sum
    send_tap(8'h7F, 8'h7F, 32'h7FFF_FFFF, 1'b1);  // bias add wraps negative
    send_tap(8'h80, 8'h7F, 32'h8000_0000, 1'b1);  // wraps positive, saturates
    send_tap(8'h05, 8'h05, 32'h7FFF_0000, 1'b1);  // saturates at the top
    send_tap(8'h02, 8'h02, 32'h5A5A_5A5A, 1'b0);  // bias ignored without last
    send_tap(8'h03, 8'h03, 32'h1234_5678, 1'b0);
    send_tap(8'h00, 8'h00, 32'h0000_0064, 1'b1);

    // Crossed clamp bounds: the lower bound wins
    wait_idle();
    program_regs(32'h0000_0001, 6'd0, 8'h00, 8'h0A, 8'hF6);
    send_tap(8'h0A, 8'h0A, 32'h0000_0000, 1'b1);
    send_tap(8'h00, 8'h00, 32'hFFFF_FFFB, 1'b1);

    // Largest multiplier and shift
    wait_idle();
    program_regs(32'hFFFF_FFFF, 6'd63, 8'h80, 8'h80, 8'h7F);
    send_tap(8'h7F, 8'h7F, 32'h0000_0000, 1'b1);
    send_tap(8'h00, 8'h00, 32'h7FFF_FFFF, 1'b1);

    // Random phases, each with its own register setting
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      case (p)
        2: program_regs(32'hFFFF_FFFF, 6'd32, 8'h80, 8'h9C, 8'h64);
        5: program_regs(32'h0000_0000, 6'd0, 8'h7F, 8'h80, 8'h7F);
        default: begin
          // multiplier sized so typical sums land inside the output range
          sh = 6'($urandom_range(40, 12));
          b  = int'(sh) - 12 + int'($urandom_range(6, 0)) - 3;
          if (b < 0) b = 0;
          if (b > 31) b = 31;
          mask = (64'd2 << b) - 64'd1;
          m  = 32'(64'($urandom) & mask) | (32'd1 << b);
          zp = 8'($urandom);
          x  = 8'($urandom);
          y  = 8'($urandom);
          if ((p == CROSSED_PHASE) ? (x < y) : (x > y)) begin
            t = x;
            x = y;
            y = t;
          end
          program_regs(m, sh, zp, x, y);
        end
      endcase
      run_taps(PHASE_ITEMS, p == HOLDOFF_PHASE);
    end

    wait_idle();
    $display("Run covered %0d taps and %0d results across %0d register settings,",
             sb.taps, sb.results, reg_sets);
    $display("including a %0d-cycle result stall with taps still offered.", HOLDOFF_CYCLES);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("[quantized_conv_mac_requant] OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived",
               sb.errors, sb.expected_results.size());
      $display("[quantized_conv_mac_requant] ERROR");
    end
    $finish;
  end

endmodule

// File: quantized_conv_mac_requant.f
+incdir+hw/rtl
hw/rtl/qcmr_pkg.sv
hw/rtl/qcmr_in_if.sv
hw/rtl/qcmr_out_if.sv
hw/rtl/qcmr_cfg_if.sv
hw/rtl/qcmr_front.sv
hw/rtl/qcmr_queue.sv
hw/rtl/qcmr_back.sv
hw/rtl/quantized_conv_mac_requant.sv
tb/quantized_conv_mac_requant_tb.sv
